// ----- rtl/rtp_h263_gob_reassembler_unit_macros.svh -----
// Assertion macros used by the reassembler top level.
`ifndef RTP_H263_GOB_REASSEMBLER_UNIT_MACROS_SVH
`define RTP_H263_GOB_REASSEMBLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTPGOB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTPGOB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rtpgob_pkg.sv -----
// Shared types, constants and helpers of the H.263 RTP reassembler.
package rtpgob_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int MAX_PAYLOAD    = 2047;
  localparam int RESULT_LIMIT   = 16;

  localparam int SEQ_W  = 16;
  localparam int LEN_W  = 11;
  localparam int SKIP_W = 3;
  localparam int FMT_W  = 3;
  localparam int HEAD_W = 32;

  localparam logic [HEAD_W-1:0] START_MASK   = 32'hffff8000;
  localparam logic [HEAD_W-1:0] START_CODE   = 32'h00008000;
  localparam logic [HEAD_W-1:0] PICTURE_MASK = 32'hfffffe00;

  localparam logic [LEN_W-1:0] HDR_LEN_A = 11'd4;
  localparam logic [LEN_W-1:0] HDR_LEN_B = 11'd8;

  typedef struct packed {
    logic [LEN_W-1:0]  count;
    logic [SEQ_W-1:0]  seq;
    logic              mode_b;
    logic [SKIP_W-1:0] sbit;
    logic [SKIP_W-1:0] ebit;
    logic              marker;
    logic [HEAD_W-1:0] head;
  } slot_entry_t;

  function automatic logic has_start_code(input logic [HEAD_W-1:0] h);
    return (h & START_MASK) == START_CODE;
  endfunction

  function automatic logic has_picture_start(input logic [HEAD_W-1:0] h);
    return (h & PICTURE_MASK) == START_CODE;
  endfunction

endpackage

// ----- rtl/rtpgob_slot_store.sv -----
// Slot ring storage: one write port, one read port, single and bulk emptying.
module rtpgob_slot_store
  import rtpgob_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int SW = $clog2(SLOT_COUNT)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  logic [SW-1:0]  wr_idx,
  input  slot_entry_t    wr_entry,
  input  logic           kill_en,
  input  logic [SW-1:0]  kill_idx,
  input  logic           clr_all,
  input  logic [SW-1:0]  rd_idx,
  output slot_entry_t    rd_entry
);

  slot_entry_t slots_r [SLOT_COUNT];
  slot_entry_t wr_kept;

  // Bulk clear also empties the slot being written
  always_comb begin
    wr_kept = wr_entry;
    if (clr_all) begin
      wr_kept.count = '0;
    end
  end

  // Write, empty one slot, or empty all slots (bulk clear wins)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        slots_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        if (wr_en && wr_idx == SW'(k)) begin
          slots_r[k] <= wr_kept;
        end else if (clr_all || (kill_en && kill_idx == SW'(k))) begin
          slots_r[k].count <= '0;
        end
      end
    end
  end

  assign rd_entry = slots_r[rd_idx];

endmodule

// ----- rtl/rtp_h263_gob_reassembler_unit.sv -----
// Top level of the H.263 (RFC 2190) RTP packet reassembly controller.
// One packet transaction is taken when start is high and busy is low; busy
// stays high until the closing scan of that packet ends. The slot index is
// found by a reciprocal multiplication, the packet is stored, and then a
// sequencer walks the slot ring through a single read port, one slot per
// cycle, probing back and forward from each mode B start code; the scan
// restarts from slot zero after each emitted chain, and a closing state
// ends the packet. A packet that changes the format returns to idle right
// after the store, with no scan. Results appear one cycle each on
// out_strobe and cannot be held off; out_run_end marks the last result of
// a packet, which is sent after the closing scan, in the first cycle with
// busy low, so a new packet can be taken while it is on the ports.
module rtp_h263_gob_reassembler_unit
  import rtpgob_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int SW = $clog2(SLOT_COUNT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [SEQ_W-1:0]  in_seq_number,
  input  logic              in_marker_bit,
  input  logic              in_mode_b_flag,
  input  logic [SKIP_W-1:0] in_start_skip_bits,
  input  logic [SKIP_W-1:0] in_end_skip_bits,
  input  logic [FMT_W-1:0]  in_source_format,
  input  logic [LEN_W-1:0]  in_payload_length,
  input  logic [HEAD_W-1:0] in_head_word,
  output logic              out_strobe,
  output logic [SW-1:0]     out_slot_index,
  output logic [LEN_W-1:0]  out_segment_length,
  output logic              out_merge_first_byte,
  output logic              out_overlap_next,
  output logic              out_chain_end,
  output logic              out_run_end
);

`include "rtp_h263_gob_reassembler_unit_macros.svh"

  localparam int NW = $clog2(RESULT_LIMIT + 1);
  localparam int FW = ((NW > SW) ? NW : SW) + 1;
  localparam int RCP_SH = SEQ_W + SW;
  localparam int RCP_W  = SEQ_W + 2;
  localparam int PRD_W  = RCP_SH + SEQ_W;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);
  localparam logic [NW-1:0] LIMIT_N  = NW'(RESULT_LIMIT);
  localparam logic [FW-1:0] LIMIT_F  = FW'(RESULT_LIMIT);
  localparam logic [SEQ_W-1:0] SLOTS_Q = SEQ_W'(SLOT_COUNT);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << RCP_SH) + 64'(SLOT_COUNT) - 64'd1)
                                            / 64'(SLOT_COUNT));

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_STORE, ST_SCAN, ST_BACK, ST_FWD, ST_EMIT, ST_FLUSH
  } state_t;

  function automatic logic [SW-1:0] idx_inc(input logic [SW-1:0] x);
    return (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [SW-1:0] idx_dec(input logic [SW-1:0] x);
    return (x == '0) ? LAST_IDX : x - 1'b1;
  endfunction

  state_t             state_r, state_nxt;
  slot_entry_t        pkt_r, pkt_nxt;
  logic [FMT_W-1:0]   fmt_r, fmt_nxt;
  logic [FMT_W-1:0]   cur_fmt_r, cur_fmt_nxt;
  logic [SEQ_W-1:0]   sh_r, sh_nxt;
  logic [SW-1:0]      rem_r, rem_nxt;
  logic               mod_ph_r, mod_ph_nxt;
  logic [SW-1:0]      i_r, i_nxt;
  logic [SW-1:0]      x_r, x_nxt;
  logic [SW-1:0]      first_r, first_nxt;
  logic [SW-1:0]      cnt_r, cnt_nxt;
  logic [SW-1:0]      last_r, last_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [SEQ_W-1:0]   exp_r, exp_nxt;

  logic               pend_v_r, pend_v_nxt;
  logic [SW-1:0]      pend_idx_r, pend_idx_nxt;
  logic [LEN_W-1:0]   pend_len_r, pend_len_nxt;
  logic               pend_merge_r, pend_merge_nxt;
  logic               pend_ovl_r, pend_ovl_nxt;
  logic               pend_end_r, pend_end_nxt;

  logic               o_strobe_r, o_strobe_nxt;
  logic [SW-1:0]      o_idx_r, o_idx_nxt;
  logic [LEN_W-1:0]   o_len_r, o_len_nxt;
  logic               o_merge_r, o_merge_nxt;
  logic               o_ovl_r, o_ovl_nxt;
  logic               o_chain_r, o_chain_nxt;
  logic               o_run_r, o_run_nxt;

  // Store-side control
  logic               wr_en, kill_en, clr_all;
  logic [SW-1:0]      kill_idx, rd_idx;
  slot_entry_t        rd;

  // New descriptor from the sequencer
  logic               emit;
  logic [SW-1:0]      e_idx;
  logic               e_merge, e_ovl, e_chain;

  logic               accept;
  logic [LEN_W-1:0]   hdr_len, raw_len, cap_len;
  logic [PRD_W-1:0]   q_prod;
  logic [SEQ_W-1:0]   q_mul;
  logic [NW-1:0]      n_inc;
  logic [FW-1:0]      need;
  logic               j0, seq_ok, found;
  logic [SW-1:0]      found_last;
  logic [SW-1:0]      back_first;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Stored length: strip the payload header, floor at zero, cap at the limit
  assign hdr_len = in_mode_b_flag ? HDR_LEN_B : HDR_LEN_A;
  assign raw_len = (in_payload_length > hdr_len) ? in_payload_length - hdr_len : '0;
  assign cap_len = (int'(raw_len) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : raw_len;

  // Slot index: quotient by reciprocal multiply, then take back the multiple
  assign q_prod = PRD_W'(sh_r) * PRD_W'(RCP);
  assign q_mul  = sh_r * SLOTS_Q;

  assign n_inc = n_r + 1'b1;
  assign j0    = (cnt_r == '0);
  assign back_first = has_start_code(rd.head) ? x_r : first_r;

  rtpgob_slot_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_idx   (rem_r),
    .wr_entry (pkt_r),
    .kill_en  (kill_en),
    .kill_idx (kill_idx),
    .clr_all  (clr_all),
    .rd_idx   (rd_idx),
    .rd_entry (rd)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    pkt_nxt     = pkt_r;
    fmt_nxt     = fmt_r;
    cur_fmt_nxt = cur_fmt_r;
    sh_nxt      = sh_r;
    rem_nxt     = rem_r;
    mod_ph_nxt  = mod_ph_r;
    i_nxt       = i_r;
    x_nxt       = x_r;
    first_nxt   = first_r;
    cnt_nxt     = cnt_r;
    last_nxt    = last_r;
    n_nxt       = n_r;
    exp_nxt     = exp_r;
    wr_en       = 1'b0;
    kill_en     = 1'b0;
    kill_idx    = x_r;
    clr_all     = 1'b0;
    rd_idx      = x_r;
    emit        = 1'b0;
    e_idx       = x_r;
    e_merge     = 1'b0;
    e_ovl       = 1'b0;
    e_chain     = 1'b0;
    seq_ok      = 1'b0;
    found       = 1'b0;
    found_last  = '0;
    need        = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pkt_nxt.count  = cap_len;
          pkt_nxt.seq    = in_seq_number;
          pkt_nxt.mode_b = in_mode_b_flag;
          pkt_nxt.sbit   = in_start_skip_bits;
          pkt_nxt.ebit   = in_end_skip_bits;
          pkt_nxt.marker = in_marker_bit;
          pkt_nxt.head   = in_head_word;
          fmt_nxt        = in_source_format;
          sh_nxt         = in_seq_number;
          rem_nxt        = '0;
          mod_ph_nxt     = 1'b0;
          state_nxt      = ST_MOD;
        end
      end

      ST_MOD: begin
        // Quotient by the slot count first (mod_ph_r low), then the remainder (mod_ph_r high)
        if (!mod_ph_r) begin
          sh_nxt     = q_prod[RCP_SH +: SEQ_W];
          mod_ph_nxt = 1'b1;
        end else begin
          rem_nxt   = SW'(pkt_r.seq - q_mul);
          state_nxt = ST_STORE;
        end
      end

      ST_STORE: begin
        wr_en = 1'b1;
        if (fmt_r != cur_fmt_r) begin
          // Adopt a new format only on a picture start; drop everything
          if (has_picture_start(pkt_r.head)) begin
            cur_fmt_nxt = fmt_r;
            clr_all     = 1'b1;
          end
          state_nxt = ST_IDLE;
        end else begin
          i_nxt     = '0;
          n_nxt     = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        rd_idx = i_r;
        if (rd.count == '0 || (rd.mode_b && !has_start_code(rd.head))) begin
          if (i_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else if (!rd.mode_b) begin
          // Mode A slot is a chain by itself
          emit     = 1'b1;
          e_idx    = i_r;
          e_chain  = 1'b1;
          kill_en  = 1'b1;
          kill_idx = i_r;
          n_nxt    = n_inc;
          i_nxt    = '0;
          if (n_inc == LIMIT_N) begin
            state_nxt = ST_FLUSH;
          end
        end else begin
          // Walk back from this start code to the earliest one in the run
          first_nxt = i_r;
          x_nxt     = idx_dec(i_r);
          exp_nxt   = rd.seq - 1'b1;
          cnt_nxt   = SW'(1);
          state_nxt = ST_BACK;
        end
      end

      ST_BACK: begin
        if (!rd.mode_b || rd.count == '0 || rd.seq != exp_r) begin
          x_nxt     = first_r;
          cnt_nxt   = '0;
          state_nxt = ST_FWD;
        end else begin
          first_nxt = back_first;
          if (cnt_r == LAST_IDX) begin
            x_nxt     = back_first;
            cnt_nxt   = '0;
            state_nxt = ST_FWD;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            x_nxt   = idx_dec(x_r);
            exp_nxt = exp_r - 1'b1;
          end
        end
      end

      ST_FWD: begin
        // Walk forward from the chain head to find where it ends
        seq_ok = j0 || (rd.seq == exp_r);
        if (!seq_ok) begin
          found = 1'b0;
        end else if (rd.count == '0 || !rd.mode_b || (!j0 && has_start_code(rd.head))) begin
          found      = !j0;
          found_last = cnt_r - 1'b1;
        end else if (rd.marker) begin
          found      = 1'b1;
          found_last = cnt_r;
        end else if (cnt_r != LAST_IDX) begin
          cnt_nxt = cnt_r + 1'b1;
          x_nxt   = idx_inc(x_r);
          exp_nxt = (j0 ? rd.seq : exp_r) + 1'b1;
        end
        need = FW'(n_r) + FW'(found_last) + 1'b1;
        if (found) begin
          if (need > LIMIT_F) begin
            state_nxt = ST_FLUSH;
          end else begin
            last_nxt  = found_last;
            x_nxt     = first_r;
            cnt_nxt   = '0;
            state_nxt = ST_EMIT;
          end
        end else if (!seq_ok || rd.count == '0 || !rd.mode_b ||
                     (!j0 && has_start_code(rd.head)) || cnt_r == LAST_IDX) begin
          // Chain not complete: resume the scan at the next slot
          if (i_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_EMIT: begin
        emit    = 1'b1;
        e_idx   = x_r;
        e_merge = (rd.sbit != '0);
        e_ovl   = (cnt_r != last_r) && (rd.ebit != '0);
        e_chain = (cnt_r == last_r);
        kill_en = 1'b1;
        n_nxt   = n_inc;
        if (cnt_r == last_r) begin
          i_nxt     = '0;
          state_nxt = (n_inc == LIMIT_N) ? ST_FLUSH : ST_SCAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          x_nxt   = idx_inc(x_r);
        end
      end

      ST_FLUSH: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold one descriptor back so the last one can carry run_end
  always_comb begin
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    pend_len_nxt   = pend_len_r;
    pend_merge_nxt = pend_merge_r;
    pend_ovl_nxt   = pend_ovl_r;
    pend_end_nxt   = pend_end_r;
    o_strobe_nxt   = 1'b0;
    o_idx_nxt      = pend_idx_r;
    o_len_nxt      = pend_len_r;
    o_merge_nxt    = pend_merge_r;
    o_ovl_nxt      = pend_ovl_r;
    o_chain_nxt    = pend_end_r;
    o_run_nxt      = 1'b0;
    if (state_r == ST_STORE) begin
      pend_v_nxt = 1'b0;
    end else if (emit) begin
      o_strobe_nxt   = pend_v_r;
      pend_v_nxt     = 1'b1;
      pend_idx_nxt   = e_idx;
      pend_len_nxt   = rd.count;
      pend_merge_nxt = e_merge;
      pend_ovl_nxt   = e_ovl;
      pend_end_nxt   = e_chain;
    end else if (state_r == ST_FLUSH) begin
      o_strobe_nxt = pend_v_r;
      o_run_nxt    = pend_v_r;
      pend_v_nxt   = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cur_fmt_r  <= '0;
      pend_v_r   <= 1'b0;
      o_strobe_r <= 1'b0;
      o_run_r    <= 1'b0;
      n_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      cur_fmt_r  <= cur_fmt_nxt;
      pend_v_r   <= pend_v_nxt;
      o_strobe_r <= o_strobe_nxt;
      o_run_r    <= o_run_nxt;
      n_r        <= n_nxt;
    end
    pkt_r        <= pkt_nxt;
    fmt_r        <= fmt_nxt;
    sh_r         <= sh_nxt;
    rem_r        <= rem_nxt;
    mod_ph_r     <= mod_ph_nxt;
    i_r          <= i_nxt;
    x_r          <= x_nxt;
    first_r      <= first_nxt;
    cnt_r        <= cnt_nxt;
    last_r       <= last_nxt;
    exp_r        <= exp_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_len_r   <= pend_len_nxt;
    pend_merge_r <= pend_merge_nxt;
    pend_ovl_r   <= pend_ovl_nxt;
    pend_end_r   <= pend_end_nxt;
    o_idx_r      <= o_idx_nxt;
    o_len_r      <= o_len_nxt;
    o_merge_r    <= o_merge_nxt;
    o_ovl_r      <= o_ovl_nxt;
    o_chain_r    <= o_chain_nxt;
  end

  assign out_strobe           = o_strobe_r;
  assign out_slot_index       = o_idx_r;
  assign out_segment_length   = o_len_r;
  assign out_merge_first_byte = o_merge_r;
  assign out_overlap_next     = o_ovl_r;
  assign out_chain_end        = o_chain_r;
  assign out_run_end          = o_run_r;

  `RTPGOB_ASSERT_NEXT(a_accept_quiet, clk, rst_n, start && !busy, !out_strobe, "result right after accept")
  `RTPGOB_ASSERT_NOW(a_run_end_strobe, clk, rst_n, out_run_end, out_strobe, "run_end without strobe")
  `RTPGOB_ASSERT_NOW(a_result_count, clk, rst_n, busy, n_r <= LIMIT_N, "result count over limit")
  `RTPGOB_ASSERT_NOW(a_overlap_not_last, clk, rst_n, out_strobe && out_chain_end, !out_overlap_next, "overlap on chain end")

endmodule
